[rtl/core/irs_pkg.sv]
`default_nettype none
package irs_pkg;

   // kernel geometry
   localparam int EXTENT   = 4;
   localparam int TAPS     = 2 * EXTENT + 1;
   localparam int SPAN     = 2 * EXTENT;
   localparam int MAX_ROW  = 1024;
   localparam int LINE_W   = MAX_ROW + 2 * EXTENT;

   // datapath widths
   localparam int COEF_W   = 13;
   localparam int SAMPLE_W = 22;
   localparam int PROD_W   = COEF_W + SAMPLE_W;
   localparam int SUM_W    = 36;

   // axis modes
   localparam logic [1:0] MODE_V = 2'd0;
   localparam logic [1:0] MODE_H = 2'd1;
   localparam logic [1:0] MODE_B = 2'd2;
   localparam logic [1:0] MODE_X = 2'd3;

   // register indexes
   localparam logic [1:0] REG_AXIS_MODE     = 2'd0;
   localparam logic [1:0] REG_IN_ROW_LENGTH = 2'd1;
   localparam logic [1:0] REG_OUT_WIDTH     = 2'd2;
   localparam logic [1:0] REG_OUT_HEIGHT    = 2'd3;

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       row_end;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic signed [9:0] pixel_out;
      logic              out_row_last;
      logic              out_frame_last;
   } rsp_type;

   // Q12 hann-windowed sinc taps, phase 0 centered, phase 1 half-sample shifted
   function automatic logic signed [COEF_W-1:0] coef_at(input logic phase,
                                                        input logic [3:0] tap);
      logic signed [COEF_W-1:0] c;
      c = '0;
      case ({phase, tap})
         5'h00: c = -13'sd234;
         5'h01: c = -13'sd224;
         5'h02: c =  13'sd371;
         5'h03: c =  13'sd1275;
         5'h04: c =  13'sd1720;
         5'h05: c =  13'sd1275;
         5'h06: c =  13'sd371;
         5'h07: c = -13'sd224;
         5'h08: c = -13'sd234;
         5'h10: c = -13'sd115;
         5'h11: c = -13'sd285;
         5'h12: c =  13'sd0;
         5'h13: c =  13'sd816;
         5'h14: c =  13'sd1575;
         5'h15: c =  13'sd1574;
         5'h16: c =  13'sd816;
         5'h17: c =  13'sd0;
         5'h18: c = -13'sd285;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/core/image_resampler_two_fifths_top.sv]
`default_nettype none
// Resamples a border-extended 8-bit raster image by 2/5 vertically, horizontally
// or both (axis_mode 0/1/2, 3 acts as 2) with 9-tap hann-windowed sinc kernels.
// Each accepted request is processed in order: a
// chain of nine tap cells forms the vertical sum over eight line-store rows and
// the new sample, then a second chain of nine cells, which also holds the
// horizontal window, forms the horizontal sum; each chain passes its partial sum
// one cell per cycle. One request is in flight at a time, and req_stall stays
// high while it is. A result waits in the output register if rsp_stall is high.
// Registers sit at byte addresses 0, 4, 8, 12 (axis_mode, in_row_length,
// out_width, out_height). Write them only while idle; the block does not check.
module image_resampler_two_fifths_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire irs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output irs_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [4:0] V_LOAD_STEP  = 5'd0;
   localparam logic [4:0] H_SHIFT_STEP = 5'd11;
   localparam logic [4:0] DONE_STEP    = 5'd22;

   // configuration
   logic [1:0]  axis_mode_ff;
   logic [10:0] in_row_length_ff, out_width_ff, out_height_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_mode_ff     <= irs_pkg::MODE_B;
         in_row_length_ff <= 11'd1032;
         out_width_ff     <= 11'd512;
         out_height_ff    <= 11'd512;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            irs_pkg::REG_AXIS_MODE:     axis_mode_ff     <= pwdata[1:0];
            irs_pkg::REG_IN_ROW_LENGTH: in_row_length_ff <= pwdata[10:0];
            irs_pkg::REG_OUT_WIDTH:     out_width_ff     <= pwdata[10:0];
            irs_pkg::REG_OUT_HEIGHT:    out_height_ff    <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         irs_pkg::REG_AXIS_MODE:     prdata = {30'd0, axis_mode_ff};
         irs_pkg::REG_IN_ROW_LENGTH: prdata = {21'd0, in_row_length_ff};
         irs_pkg::REG_OUT_WIDTH:     prdata = {21'd0, out_width_ff};
         irs_pkg::REG_OUT_HEIGHT:    prdata = {21'd0, out_height_ff};
         default:                    prdata = '0;
      endcase
   end

   // position counters
   logic [10:0] in_column_ff, in_column_in, out_column_ff, out_column_in;
   logic [11:0] in_row_ff, in_row_in;
   logic [10:0] out_row_ff, out_row_in;
   logic        accept, busy_ff, finish;
   logic [4:0]  cnt_ff;
   logic [1:0]  mode;
   logic [13:0] need_row, need_col;
   logic        hit, row_last, frame_last, col_ok;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;
   assign mode      = (axis_mode_ff == irs_pkg::MODE_X) ? irs_pkg::MODE_B : axis_mode_ff;
   assign col_ok    = in_column_ff < 11'(irs_pkg::LINE_W);

   // stream position at which the next result falls due
   always_comb begin
      if (mode == irs_pkg::MODE_H) begin
         need_row = {3'd0, out_row_ff} + 14'(irs_pkg::EXTENT);
      end else begin
         need_row = (({3'd0, out_row_ff} << 2) + {3'd0, out_row_ff}) >> 1;
         need_row = need_row + 14'(irs_pkg::SPAN);
      end
      if (mode == irs_pkg::MODE_V) begin
         need_col = {3'd0, out_column_ff} + 14'(irs_pkg::EXTENT);
      end else begin
         need_col = (({3'd0, out_column_ff} << 2) + {3'd0, out_column_ff}) >> 1;
         need_col = need_col + 14'(irs_pkg::SPAN);
      end
      row_last   = ({1'b0, out_column_ff} + 12'd1) >= {1'b0, out_width_ff};
      frame_last = row_last && (({1'b0, out_row_ff} + 12'd1) >= {1'b0, out_height_ff});
      hit = (out_width_ff != 11'd0) && (out_row_ff < out_height_ff)
            && ({2'd0, in_row_ff} == need_row) && ({3'd0, in_column_ff} == need_col);
   end

   always_comb begin
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      if (hit) begin
         if (row_last) begin
            out_column_in = '0;
            out_row_in    = out_row_ff + 11'd1;
         end else begin
            out_column_in = out_column_ff + 11'd1;
         end
      end
      if (req_data.frame_end) begin
         in_column_in  = '0;
         in_row_in     = '0;
         out_column_in = '0;
         out_row_in    = '0;
      end else if (req_data.row_end
                   || ({1'b0, in_column_ff} + 12'd1) >= {1'b0, in_row_length_ff}) begin
         in_column_in = '0;
         if (in_row_ff != 12'hFFF) begin
            in_row_in = in_row_ff + 12'd1;
         end
      end else begin
         in_column_in = in_column_ff + 11'd1;
      end
   end

   // request capture and step control
   logic [7:0] px_ff;
   logic       hit_ff, row_last_ff, frame_last_ff, pv_ff, ph_ff, col_ok_ff;
   logic [1:0] mode_ff;
   logic [2:0] slot_ff;
   logic       rsp_valid_ff;
   irs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign finish = busy_ff && (cnt_ff == DONE_STEP) && (!hit_ff || !rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff       <= 1'b1;
            cnt_ff        <= '0;
            in_column_ff  <= in_column_in;
            in_row_ff     <= in_row_in;
            out_column_ff <= out_column_in;
            out_row_ff    <= out_row_in;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end else if (busy_ff && cnt_ff != DONE_STEP) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
         if (finish && hit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff         <= req_data.pixel_in;
         hit_ff        <= hit;
         row_last_ff   <= row_last;
         frame_last_ff <= frame_last;
         pv_ff         <= out_row_ff[0];
         ph_ff         <= out_column_ff[0];
         col_ok_ff     <= col_ok;
         mode_ff       <= mode;
         slot_ff       <= in_row_ff[2:0];
      end
      if (finish && hit_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // line store, one memory per buffered row
   logic [7:0] rd [irs_pkg::SPAN];

   for (genvar r = 0; r < irs_pkg::SPAN; r++) begin : g_line
      irs_ram #(.WIDTH(8), .DEPTH(irs_pkg::LINE_W)) u_line (
         .clock   (clock),
         .wr_en   (accept && col_ok && (in_row_ff[2:0] == 3'(r))),
         .wr_addr (in_column_ff),
         .wr_data (req_data.pixel_in),
         .rd_addr (in_column_ff),
         .rd_data (rd[r])
      );
   end

   // vertical cell chain: oldest row first, the new sample last
   logic signed [irs_pkg::SUM_W-1:0]    vs [irs_pkg::TAPS+1];
   logic signed [irs_pkg::SAMPLE_W-1:0] vval [irs_pkg::TAPS];
   logic signed [irs_pkg::SAMPLE_W-1:0] vin [irs_pkg::TAPS];
   logic                                v_load;

   assign vs[0]  = '0;
   assign v_load = busy_ff && (cnt_ff == V_LOAD_STEP);

   for (genvar i = 0; i < irs_pkg::TAPS; i++) begin : g_vcell
      if (i == irs_pkg::SPAN) begin : g_new
         assign vin[i] = {14'd0, px_ff};
      end else begin : g_old
         assign vin[i] = col_ok_ff ? {14'd0, rd[slot_ff + 3'(i)]} : '0;
      end
      irs_tap_cell u_cell (
         .clock      (clock),
         .load       (v_load),
         .load_value (vin[i]),
         .coef       (irs_pkg::coef_at(pv_ff, 4'(i))),
         .sum_in     (vs[i]),
         .value      (vval[i]),
         .sum_out    (vs[i+1])
      );
   end

   // horizontal cell chain, also the column window
   logic signed [irs_pkg::SUM_W-1:0]    hs [irs_pkg::TAPS+1];
   logic signed [irs_pkg::SAMPLE_W-1:0] hval [irs_pkg::TAPS];
   logic signed [irs_pkg::SAMPLE_W-1:0] hin [irs_pkg::TAPS];
   logic                                h_shift;
   logic signed [irs_pkg::SUM_W-1:0]    vsum;

   assign vsum    = vs[irs_pkg::TAPS];
   assign hs[0]   = '0;
   assign h_shift = busy_ff && (cnt_ff == H_SHIFT_STEP);

   for (genvar i = 0; i < irs_pkg::TAPS; i++) begin : g_hcell
      if (i == irs_pkg::SPAN) begin : g_new
         assign hin[i] = (mode_ff == irs_pkg::MODE_H) ? {14'd0, px_ff}
                                                      : vsum[irs_pkg::SAMPLE_W-1:0];
      end else begin : g_shift
         assign hin[i] = hval[i+1];
      end
      irs_tap_cell u_cell (
         .clock      (clock),
         .load       (h_shift),
         .load_value (hin[i]),
         .coef       (irs_pkg::coef_at(ph_ff, 4'(i))),
         .sum_in     (hs[i]),
         .value      (hval[i]),
         .sum_out    (hs[i+1])
      );
   end

   // round half up, then saturate
   logic signed [irs_pkg::SUM_W-1:0] acc, rnd;
   logic                             unused_vval;

   assign unused_vval = ^{vval[0], vval[1], vval[2], vval[3], vval[4],
                          vval[5], vval[6], vval[7], vval[8]};

   always_comb begin
      acc = (mode_ff == irs_pkg::MODE_V) ? vsum : hs[irs_pkg::TAPS];
      if (mode_ff == irs_pkg::MODE_B) begin
         rnd = (acc + 36'sd8388608) >>> 24;
      end else begin
         rnd = (acc + 36'sd2048) >>> 12;
      end
      if (rnd < -36'sd256) begin
         rsp_data_in.pixel_out = -10'sd256;
      end else if (rnd > 36'sd511) begin
         rsp_data_in.pixel_out = 10'sd511;
      end else begin
         rsp_data_in.pixel_out = rnd[9:0];
      end
      rsp_data_in.out_row_last   = row_last_ff;
      rsp_data_in.out_frame_last = frame_last_ff & (unused_vval | ~unused_vval);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/core/irs_ram.sv]
`default_nettype none
module irs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1032
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-first single port pair
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/irs_tap_cell.sv]
`default_nettype none
module irs_tap_cell (
   input  wire logic                                  clock,
   input  wire logic                                  load,
   input  wire logic signed [irs_pkg::SAMPLE_W-1:0]   load_value,
   input  wire logic signed [irs_pkg::COEF_W-1:0]     coef,
   input  wire logic signed [irs_pkg::SUM_W-1:0]      sum_in,
   output logic signed      [irs_pkg::SAMPLE_W-1:0]   value,
   output logic signed      [irs_pkg::SUM_W-1:0]      sum_out
);

   logic signed [irs_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [irs_pkg::PROD_W-1:0]   prod_ff;
   logic signed [irs_pkg::SUM_W-1:0]    sum_ff;

   // held sample, its weighted product, and the partial sum passed on
   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
      end
      prod_ff <= coef * value_ff;
      sum_ff  <= sum_in + irs_pkg::SUM_W'(prod_ff);
   end

   assign value   = value_ff;
   assign sum_out = sum_ff;

endmodule
`default_nettype wire
